FILE: design/gsa_pkg.sv
// types and codes shared by the generational slot allocator
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

  localparam logic REQ_CREATE  = 1'b0;
  localparam logic REQ_DESTROY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOT_LIVE = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [2:0] comp_type;
    logic [7:0] handle_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  assigned_id;
    logic [31:0] generation;
    logic [7:0]  dense_index;
    logic        moved_valid;
    logic [7:0]  moved_id;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CFIFO,
    S_CGEN,
    S_DCHK,
    S_DMOVE,
    S_DONE
  } gsa_state_t;

endpackage

`default_nettype wire

FILE: design/gsa_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/generational_slot_allocator.sv
// generational slot allocator: per-type handle pools with densely packed slots
//
// in_data carries one request beat (create or destroy, type, id); out_data
// returns exactly one result beat per request. a beat moves on a channel at a
// rising edge where its valid is high and its stall is low.
// create goes from accept through type state and id map reads, free ring
// read, generation read, then the result stage. destroy goes through type
// state and id map reads, slot map check, last-slot read, result. a request
// with a bad type goes straight to the result. the block handles one request
// at a time and holds in_stall high until its result has been moved into the
// output register; every step goes through single read port rams, the type
// state ram first. a request that fails a check goes to the result early.
// the output register lets the next request start while a result waits; if
// out_stall stays high the finished result holds in its stage and the block
// stops taking requests.
// after reset all pools are empty, every generation is zero and each free ring
// holds its ids in ascending order; the block is ready in the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_allocator
  import gsa_pkg::*;
#(
  parameter int NUM_TYPES    = 8,
  parameter int MAX_PER_TYPE = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  localparam int IW    = $clog2(MAX_PER_TYPE);
  localparam int CW    = $clog2(MAX_PER_TYPE + 1);
  localparam int TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int DEPTH = NUM_TYPES * MAX_PER_TYPE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TSW   = CW + IW + CW;

  localparam logic [AW-1:0] MAX_A  = AW'(MAX_PER_TYPE);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_PER_TYPE);
  localparam logic [CW:0]   MAX_C1 = (CW+1)'(MAX_PER_TYPE);

  function automatic logic [AW-1:0] mem_addr(input logic [TW-1:0] t,
                                             input logic [IW-1:0] i);
    return AW'(t) * MAX_A + AW'(i);
  endfunction

  gsa_state_t state_r, state_nxt;

  logic            req_r, req_nxt;
  logic [TW-1:0]   t_r, t_nxt;
  logic [7:0]      hid_r, hid_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [IW-1:0]   hole_r, hole_nxt;
  logic [IW-1:0]   id_r, id_nxt;
  logic            from_mem_r, from_mem_nxt;
  logic [31:0]     gen_r, gen_nxt;
  out_beat_t       res_r, res_nxt;
  out_beat_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [NUM_TYPES-1:0] ts_vld_r, ts_vld_nxt;

  // type state ram: {live count, ring head, ring fill count}
  logic            ts_we;
  logic [TW-1:0]   ts_rd_addr;
  logic [TSW-1:0]  ts_wr_data, ts_rd_data, ts_q;
  logic [CW-1:0]   ts_cnt, ts_fill;
  logic [IW-1:0]   ts_head;

  logic            fifo_we;
  logic [AW-1:0]   fifo_wr_addr, fifo_rd_addr;
  logic [IW-1:0]   fifo_wr_data, fifo_rd_data;

  logic            gen_we;
  logic [AW-1:0]   gen_wr_addr, gen_rd_addr;
  logic [31:0]     gen_wr_data, gen_rd_data;

  logic            i2s_we;
  logic [AW-1:0]   i2s_wr_addr, i2s_rd_addr;
  logic [IW-1:0]   i2s_wr_data, i2s_rd_data;

  logic            s2i_we;
  logic [AW-1:0]   s2i_wr_addr, s2i_rd_addr;
  logic [IW-1:0]   s2i_wr_data, s2i_rd_data;

  logic            accept;
  logic            out_free;
  logic            hid_ok;
  logic [IW-1:0]   id_sel;
  logic            sel_mem;
  logic [31:0]     gen_v;
  logic [CW-1:0]   last;
  logic            moved;
  logic [CW:0]     pos_sum;
  logic [CW:0]     pos_wrap;
  logic [IW-1:0]   head_inc;
  logic [CW-1:0]   fill_inc;

  gsa_ram #(.WIDTH(TSW), .DEPTH(NUM_TYPES)) u_ts_ram (
    .clk(clk), .wr_en(ts_we), .wr_addr(t_r), .wr_data(ts_wr_data),
    .rd_addr(ts_rd_addr), .rd_data(ts_rd_data)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_fifo_ram (
    .clk(clk), .wr_en(fifo_we), .wr_addr(fifo_wr_addr), .wr_data(fifo_wr_data),
    .rd_addr(fifo_rd_addr), .rd_data(fifo_rd_data)
  );

  gsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_gen_ram (
    .clk(clk), .wr_en(gen_we), .wr_addr(gen_wr_addr), .wr_data(gen_wr_data),
    .rd_addr(gen_rd_addr), .rd_data(gen_rd_data)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_i2s_ram (
    .clk(clk), .wr_en(i2s_we), .wr_addr(i2s_wr_addr), .wr_data(i2s_wr_data),
    .rd_addr(i2s_rd_addr), .rd_data(i2s_rd_data)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_s2i_ram (
    .clk(clk), .wr_en(s2i_we), .wr_addr(s2i_wr_addr), .wr_data(s2i_wr_data),
    .rd_addr(s2i_rd_addr), .rd_data(s2i_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // never-written type state reads as empty
  assign ts_q = ts_vld_r[t_r] ? ts_rd_data : '0;
  assign {ts_cnt, ts_head, ts_fill} = ts_q;

  assign ts_rd_addr   = TW'(in_data.comp_type);
  assign i2s_rd_addr  = mem_addr(TW'(in_data.comp_type), IW'(in_data.handle_id));
  assign fifo_rd_addr = mem_addr(t_r, ts_head);

  assign hid_ok   = 32'(hid_r) < MAX_PER_TYPE;
  // ring slots not yet pushed since reset still hold their own index
  assign sel_mem  = CW'(head_r) < fill_r;
  assign id_sel   = sel_mem ? fifo_rd_data : head_r;
  assign gen_v    = from_mem_r ? gen_rd_data : '0;
  assign last     = cnt_r - CW'(1);
  assign moved    = CW'(hole_r) != last;
  assign pos_sum  = (CW+1)'(head_r) + MAX_C1 - (CW+1)'(cnt_r);
  assign pos_wrap = (pos_sum >= MAX_C1) ? pos_sum - MAX_C1 : pos_sum;
  assign head_inc = (CW'(head_r) + CW'(1) == MAX_C) ? '0 : head_r + IW'(1);
  assign fill_inc = (fill_r == MAX_C) ? fill_r : fill_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ts_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ts_vld_r    <= ts_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    t_r        <= t_nxt;
    hid_r      <= hid_nxt;
    cnt_r      <= cnt_nxt;
    head_r     <= head_nxt;
    fill_r     <= fill_nxt;
    hole_r     <= hole_nxt;
    id_r       <= id_nxt;
    from_mem_r <= from_mem_nxt;
    gen_r      <= gen_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    t_nxt         = t_r;
    hid_nxt       = hid_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    hole_nxt      = hole_r;
    id_nxt        = id_r;
    from_mem_nxt  = from_mem_r;
    gen_nxt       = gen_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ts_vld_nxt    = ts_vld_r;

    ts_we         = 1'b0;
    ts_wr_data    = {cnt_r, head_r, fill_r};
    fifo_we       = 1'b0;
    fifo_wr_addr  = mem_addr(t_r, IW'(pos_wrap));
    fifo_wr_data  = IW'(hid_r);
    gen_we        = 1'b0;
    gen_wr_addr   = mem_addr(t_r, id_r);
    gen_wr_data   = gen_v;
    gen_rd_addr   = mem_addr(t_r, IW'(hid_r));
    i2s_we        = 1'b0;
    i2s_wr_addr   = mem_addr(t_r, id_r);
    i2s_wr_data   = IW'(cnt_r);
    s2i_we        = 1'b0;
    s2i_wr_addr   = mem_addr(t_r, IW'(cnt_r));
    s2i_wr_data   = id_r;
    s2i_rd_addr   = mem_addr(t_r, i2s_rd_data);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data.req_type;
          t_nxt   = TW'(in_data.comp_type);
          hid_nxt = in_data.handle_id;
          if (32'(in_data.comp_type) >= NUM_TYPES) begin
            res_nxt        = '0;
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        cnt_nxt  = ts_cnt;
        head_nxt = ts_head;
        fill_nxt = ts_fill;
        hole_nxt = i2s_rd_data;
        res_nxt  = '0;
        if (req_r == REQ_CREATE) begin
          if (ts_cnt == MAX_C) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_CFIFO;
          end
        end else begin
          if (ts_cnt == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end else if (!hid_ok || (CW'(i2s_rd_data) >= ts_cnt)) begin
            res_nxt.status = ST_NOT_LIVE;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_DCHK;
          end
        end
      end

      S_CFIFO: begin
        id_nxt       = id_sel;
        from_mem_nxt = sel_mem;
        gen_rd_addr  = mem_addr(t_r, id_sel);
        state_nxt    = S_CGEN;
      end

      S_CGEN: begin
        gen_we      = 1'b1;
        i2s_we      = 1'b1;
        s2i_we      = 1'b1;
        ts_we       = 1'b1;
        ts_wr_data  = {cnt_r + CW'(1), head_inc, fill_r};
        ts_vld_nxt[t_r] = 1'b1;
        res_nxt             = '0;
        res_nxt.status      = ST_OK;
        res_nxt.assigned_id = 8'(id_r);
        res_nxt.generation  = gen_v;
        res_nxt.dense_index = 8'(cnt_r);
        state_nxt   = S_DONE;
      end

      S_DCHK: begin
        gen_nxt     = gen_rd_data + 32'd1;
        s2i_rd_addr = mem_addr(t_r, IW'(last));
        if (s2i_rd_data != IW'(hid_r)) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOT_LIVE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_DMOVE;
        end
      end

      S_DMOVE: begin
        // last dense item fills the hole
        s2i_we      = moved;
        s2i_wr_addr = mem_addr(t_r, hole_r);
        s2i_wr_data = s2i_rd_data;
        i2s_we      = moved;
        i2s_wr_addr = mem_addr(t_r, s2i_rd_data);
        i2s_wr_data = hole_r;
        fifo_we     = 1'b1;
        gen_we      = 1'b1;
        gen_wr_addr = mem_addr(t_r, IW'(hid_r));
        gen_wr_data = gen_r;
        ts_we       = 1'b1;
        ts_wr_data  = {last, head_r, fill_inc};
        ts_vld_nxt[t_r] = 1'b1;
        res_nxt             = '0;
        res_nxt.status      = ST_OK;
        res_nxt.assigned_id = hid_r;
        res_nxt.generation  = gen_r;
        res_nxt.dense_index = 8'(hole_r);
        res_nxt.moved_valid = moved;
        res_nxt.moved_id    = moved ? 8'(s2i_rd_data) : 8'd0;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
